// File: rtl/core/morse_text_codec_core_defines.svh
// Assertion macros shared by the morse text codec RTL.
// Needs a clock named clk and an active-low reset named arst_n in scope.
`ifndef MORSE_TEXT_CODEC_CORE_DEFINES_SVH
`define MORSE_TEXT_CODEC_CORE_DEFINES_SVH

// Condition must never hold outside reset.
`define MTC_ASSERT_NEVER(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) !(cond)) else $error(msg);

// Antecedent implies consequent in the same cycle.
`define MTC_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent in the next cycle.
`define MTC_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

// File: rtl/core/mtc_pkg.sv
// Shared types, Morse table and lookup functions for the morse text codec.
// No dependencies; imported by every module of the block.
package mtc_pkg;

	localparam int MTC_MAX_SYMBOLS = 5;
	localparam int MTC_QUEUE_DEPTH = 2;

	localparam int TABLE_SIZE    = 37;
	localparam int TABLE_MAX_LEN = 5;
	localparam int IDX_W         = $clog2(TABLE_SIZE);
	localparam int SYM_W         = 2 * TABLE_MAX_LEN;
	localparam int PAT_LEN_W     = $clog2(TABLE_MAX_LEN + 1);
	localparam int MAX_BEATS     = TABLE_MAX_LEN + 1;
	localparam int STEP_W        = $clog2(MAX_BEATS);

	localparam logic [7:0] CHAR_LC_A   = 8'd97;
	localparam logic [7:0] CHAR_LC_Z   = 8'd122;
	localparam logic [7:0] CHAR_ZERO   = 8'd48;
	localparam logic [7:0] CHAR_ONE    = 8'd49;
	localparam logic [7:0] CHAR_NINE   = 8'd57;
	localparam logic [7:0] CHAR_DASH   = 8'd45;
	localparam logic [7:0] CHAR_DOT    = 8'd46;
	localparam logic [7:0] CHAR_SLASH  = 8'd47;
	localparam logic [7:0] CHAR_SPACE  = 8'd32;

	localparam logic [1:0] SYM_NONE  = 2'd0;
	localparam logic [1:0] SYM_DOT   = 2'd1;
	localparam logic [1:0] SYM_DASH  = 2'd2;
	localparam logic [1:0] SYM_SLASH = 2'd3;

	localparam logic [IDX_W-1:0] IDX_DIGIT_ONE  = IDX_W'(26);
	localparam logic [IDX_W-1:0] IDX_DIGIT_ZERO = IDX_W'(35);
	localparam logic [IDX_W-1:0] IDX_SPACE      = IDX_W'(36);

	// Symbol i at bits 2i+1..2i: dot 01, dash 10, slash 11.
	localparam logic [SYM_W-1:0] PAT_SYM [TABLE_SIZE] = '{
		10'b00_00_00_10_01, 10'b00_01_01_01_10, 10'b00_01_10_01_10, 10'b00_00_01_01_10,
		10'b00_00_00_00_01, 10'b00_01_10_01_01, 10'b00_00_01_10_10, 10'b00_01_01_01_01,
		10'b00_00_00_01_01, 10'b00_10_10_10_01, 10'b00_00_10_01_10, 10'b00_01_01_10_01,
		10'b00_00_00_10_10, 10'b00_00_00_01_10, 10'b00_00_10_10_10, 10'b00_01_10_10_01,
		10'b00_10_01_10_10, 10'b00_00_01_10_01, 10'b00_00_01_01_01, 10'b00_00_00_00_10,
		10'b00_00_10_01_01, 10'b00_10_01_01_01, 10'b00_00_10_10_01, 10'b00_10_01_01_10,
		10'b00_10_10_01_10, 10'b00_01_01_10_10,
		10'b10_10_10_10_01, 10'b10_10_10_01_01, 10'b10_10_01_01_01, 10'b10_01_01_01_01,
		10'b01_01_01_01_01, 10'b01_01_01_01_10, 10'b01_01_01_10_10, 10'b01_01_10_10_10,
		10'b01_10_10_10_10, 10'b10_10_10_10_10,
		10'b00_00_00_11_11
	};

	localparam logic [PAT_LEN_W-1:0] PAT_LEN [TABLE_SIZE] = '{
		3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4, 3'd3, 3'd4, 3'd2,
		3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1, 3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4,
		3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5, 3'd5,
		3'd2
	};

	typedef struct packed {
		logic             hit;
		logic [IDX_W-1:0] idx;
	} enc_lookup_t;

	typedef struct packed {
		logic       hit;
		logic [7:0] glyph;
	} dec_lookup_t;

	// One queued job: an encode character or the outcome of one decode byte.
	typedef struct packed {
		logic             enc;
		logic [IDX_W-1:0] idx;
		logic             bad;
		logic             chr_valid;
		logic [7:0]       chr;
	} mtc_job_t;

	function automatic logic [1:0] mtc_sym_code(input logic [7:0] c);
		logic [1:0] code;
		unique case (c)
			CHAR_DOT:   code = SYM_DOT;
			CHAR_DASH:  code = SYM_DASH;
			CHAR_SLASH: code = SYM_SLASH;
			default:    code = SYM_NONE;
		endcase
		return code;
	endfunction

	function automatic logic [7:0] mtc_sym_char(input logic [1:0] code);
		logic [7:0] c;
		unique case (code)
			SYM_DOT:   c = CHAR_DOT;
			SYM_DASH:  c = CHAR_DASH;
			SYM_SLASH: c = CHAR_SLASH;
			default:   c = 8'd0;
		endcase
		return c;
	endfunction

	function automatic logic [7:0] mtc_glyph(input logic [IDX_W-1:0] idx);
		logic [7:0] c;
		if (idx < IDX_DIGIT_ONE)
			c = CHAR_LC_A + 8'(idx);
		else if (idx < IDX_DIGIT_ZERO)
			c = CHAR_ONE + 8'(idx - IDX_DIGIT_ONE);
		else if (idx == IDX_DIGIT_ZERO)
			c = CHAR_ZERO;
		else
			c = CHAR_SPACE;
		return c;
	endfunction

	function automatic enc_lookup_t mtc_enc_lookup(input logic [7:0] c);
		enc_lookup_t r;
		r = '0;
		if (c >= CHAR_LC_A && c <= CHAR_LC_Z) begin
			r.hit = 1'b1;
			r.idx = IDX_W'(c - CHAR_LC_A);
		end else if (c >= CHAR_ONE && c <= CHAR_NINE) begin
			r.hit = 1'b1;
			r.idx = IDX_DIGIT_ONE + IDX_W'(c - CHAR_ONE);
		end else if (c == CHAR_ZERO) begin
			r.hit = 1'b1;
			r.idx = IDX_DIGIT_ZERO;
		end else if (c == CHAR_SPACE) begin
			r.hit = 1'b1;
			r.idx = IDX_SPACE;
		end
		return r;
	endfunction

	// Patterns are unique, so at most one entry matches.
	function automatic dec_lookup_t mtc_dec_lookup(input logic [SYM_W-1:0] sym,
			input logic [PAT_LEN_W-1:0] len);
		dec_lookup_t r;
		r = '0;
		for (int j = 0; j < TABLE_SIZE; j++) begin
			if (PAT_SYM[j] == sym && PAT_LEN[j] == len) begin
				r.hit   = 1'b1;
				r.glyph = r.glyph | mtc_glyph(IDX_W'(j));
			end
		end
		return r;
	endfunction

endpackage

// File: rtl/core/mtc_front.sv
// Front end: accepts input bytes, holds direction and the decode token,
// classifies each byte and queues a job for each that yields a result. Depends on mtc_pkg.
module mtc_front import mtc_pkg::*; #(
	parameter int MAX_SYMBOLS = MTC_MAX_SYMBOLS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       push,
	input  logic [7:0] in_char,
	input  logic       end_of_line,
	input  logic       cfg_we,
	input  logic       cfg_wdata,
	input  logic       q_full,
	output logic       q_push,
	output mtc_job_t   q_job
);

	localparam int LenW = $clog2(MAX_SYMBOLS + 1);

	logic             dir_q;
	logic [LenW-1:0]  tok_len_q, tok_len_n;
	logic [SYM_W-1:0] tok_sym_q, tok_sym_n;
	logic             tok_long_q, tok_long_n;

	logic        accept;
	logic [1:0]  code;
	logic        is_sym, is_space, end_tok, bad_dec, len_ok, chr_valid;
	enc_lookup_t enc;
	dec_lookup_t dec;

	assign accept   = push && !q_full;
	assign code     = mtc_sym_code(in_char);
	assign is_sym   = code != SYM_NONE;
	assign is_space = in_char == CHAR_SPACE;
	assign end_tok  = is_space || end_of_line;
	assign bad_dec  = !is_sym && !is_space;
	assign enc      = mtc_enc_lookup(in_char);

	// Token after this byte's symbol, if any; the end check sees it.
	always_comb begin
		tok_len_n  = tok_len_q;
		tok_sym_n  = tok_sym_q;
		tok_long_n = tok_long_q;
		if (is_sym) begin
			if (tok_len_q >= LenW'(MAX_SYMBOLS)) begin
				tok_long_n = 1'b1;
			end else begin
				for (int i = 0; i < TABLE_MAX_LEN; i++) begin
					if (tok_len_q == LenW'(i))
						tok_sym_n[2*i +: 2] = code;
				end
				tok_len_n = tok_len_q + LenW'(1);
			end
		end
	end

	assign len_ok    = tok_len_n != '0 && tok_len_n <= LenW'(TABLE_MAX_LEN);
	assign dec       = mtc_dec_lookup(tok_sym_n, tok_len_n[PAT_LEN_W-1:0]);
	assign chr_valid = end_tok && !tok_long_n && len_ok && dec.hit;

	always_comb begin
		q_job.enc       = !dir_q;
		q_job.idx       = enc.idx;
		q_job.bad       = dir_q ? bad_dec : !enc.hit;
		q_job.chr_valid = dir_q && chr_valid;
		q_job.chr       = dec.glyph;
	end

	// Decode bytes that make no result (symbols, empty ends) stay out of the queue.
	assign q_push = accept && (!dir_q || bad_dec || chr_valid);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q      <= 1'b0;
			tok_len_q  <= '0;
			tok_sym_q  <= '0;
			tok_long_q <= 1'b0;
		end else begin
			if (cfg_we)
				dir_q <= cfg_wdata;
			if (accept && dir_q) begin
				if (end_tok) begin
					tok_len_q  <= '0;
					tok_sym_q  <= '0;
					tok_long_q <= 1'b0;
				end else begin
					tok_len_q  <= tok_len_n;
					tok_sym_q  <= tok_sym_n;
					tok_long_q <= tok_long_n;
				end
			end
		end
	end

endmodule

// File: rtl/core/mtc_queue.sv
// Short job queue between front and back end.
// Depends on mtc_pkg and the shared assertion macros.
`include "morse_text_codec_core_defines.svh"
module mtc_queue import mtc_pkg::*; #(
	parameter int DEPTH = MTC_QUEUE_DEPTH
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     q_push,
	input  mtc_job_t q_job,
	output logic     q_full,
	input  logic     q_pop,
	output logic     head_valid,
	output mtc_job_t head_job
);

	localparam int PtrW = $clog2(DEPTH);
	localparam int CntW = $clog2(DEPTH + 1);

	mtc_job_t        mem_q [DEPTH];
	logic [PtrW-1:0] wr_ptr_q, rd_ptr_q;
	logic [CntW-1:0] count_q;

	function automatic logic [PtrW-1:0] wrap_inc(input logic [PtrW-1:0] p);
		return (p == PtrW'(DEPTH - 1)) ? '0 : p + PtrW'(1);
	endfunction

	assign q_full     = count_q == CntW'(DEPTH);
	assign head_valid = count_q != '0;
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_push)
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (q_pop)
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (q_push && !q_pop)
				count_q <= count_q + CntW'(1);
			else if (q_pop && !q_push)
				count_q <= count_q - CntW'(1);
		end
	end

	always_ff @(posedge clk) begin
		if (q_push)
			mem_q[wr_ptr_q] <= q_job;
	end

	`MTC_ASSERT_NEVER(a_no_push_full, q_push && q_full, "job pushed into full queue")
	`MTC_ASSERT_NEVER(a_no_pop_empty, q_pop && !head_valid, "job popped from empty queue")
	`MTC_ASSERT_NEVER(a_count_range, count_q > CntW'(DEPTH), "queue count out of range")

endmodule

// File: rtl/core/mtc_back.sv
// Back end: expands the head job into result beats, one per cycle unless the consumer
// stalls pop, into a single output register. Depends on mtc_pkg and the assertion macros.
`include "morse_text_codec_core_defines.svh"
module mtc_back import mtc_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       head_valid,
	input  mtc_job_t   head_job,
	output logic       q_pop,
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       bad_input,
	output logic       last_of_run
);

	logic [STEP_W-1:0]    step_q;
	logic                 out_valid_q;
	logic [7:0]           out_char_q;
	logic                 bad_q, last_q;

	logic                 load;
	logic [7:0]           beat_char;
	logic                 beat_bad, beat_last;
	logic [PAT_LEN_W-1:0] plen;
	logic [SYM_W-1:0]     psym;

	assign plen = PAT_LEN[head_job.idx];
	assign psym = PAT_SYM[head_job.idx] >> {step_q, 1'b0};

	always_comb begin
		beat_char = '0;
		beat_bad  = 1'b0;
		beat_last = 1'b0;
		if (head_job.enc) begin
			if (head_job.bad) begin
				beat_bad  = 1'b1;
				beat_last = 1'b1;
			end else if (step_q < STEP_W'(plen)) begin
				beat_char = mtc_sym_char(psym[1:0]);
			end else begin
				beat_char = CHAR_SPACE;
				beat_last = 1'b1;
			end
		end else begin
			if (head_job.bad && step_q == '0) begin
				beat_bad  = 1'b1;
				beat_last = !head_job.chr_valid;
			end else begin
				beat_char = head_job.chr;
				beat_last = 1'b1;
			end
		end
	end

	assign load  = head_valid && (!out_valid_q || pop);
	assign q_pop = load && beat_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				step_q      <= beat_last ? '0 : step_q + STEP_W'(1);
				out_valid_q <= 1'b1;
			end else if (pop) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			out_char_q <= beat_char;
			bad_q      <= beat_bad;
			last_q     <= beat_last;
		end
	end

	assign empty       = !out_valid_q;
	assign out_char    = out_char_q;
	assign bad_input   = bad_q;
	assign last_of_run = last_q;

	`MTC_ASSERT_NEVER(a_step_range, step_q >= STEP_W'(MAX_BEATS), "beat step out of range")
	`MTC_ASSERT_IMP(a_job_has_beat, head_valid, head_job.enc || head_job.bad || head_job.chr_valid,
		"queued job yields no beat")
	`MTC_ASSERT_NEXT(a_step_clears, q_pop, step_q == '0, "step not cleared after last beat")

endmodule

// File: rtl/core/morse_text_codec_core.sv
// Morse text codec core. An accepted byte passes the job queue, then the output register, before its first beat.
// Input beats are taken every cycle while the job queue has room; results leave one beat
// per cycle from the output register while the consumer pops. An encode byte yields pattern length + 1 beats (2..6
// beats), a byte outside the table one beat; decode 0, 1 or 2 beats, so the output beat
// rate of the back end sets sustained throughput.
// arst_n clears direction (encode), the decode token and the queue, and empties the output register.
module morse_text_codec_core import mtc_pkg::*; #(
	parameter int MAX_SYMBOLS = MTC_MAX_SYMBOLS,
	parameter int QUEUE_DEPTH = MTC_QUEUE_DEPTH
) (
	input  logic       clk,
	input  logic       arst_n,
	// input side, queue style
	input  logic       push,
	output logic       full,
	input  logic [7:0] in_char,
	input  logic       end_of_line,
	// result side, queue style
	output logic       empty,
	input  logic       pop,
	output logic [7:0] out_char,
	output logic       bad_input,
	output logic       last_of_run,
	// direction register: 0 text to Morse, 1 Morse to text
	input  logic       cfg_we,
	input  logic       cfg_wdata
);

	// Front classifies each beat and queues a job for those that yield a result; the queue
	// decouples it from the back end, which may spend up to six beats expanding one encode job.
	logic     q_push, q_full, q_pop, head_valid;
	mtc_job_t q_job, head_job;

	assign full = q_full;

	mtc_front #(
		.MAX_SYMBOLS(MAX_SYMBOLS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.in_char     (in_char),
		.end_of_line (end_of_line),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.q_full      (q_full),
		.q_push      (q_push),
		.q_job       (q_job)
	);

	mtc_queue #(
		.DEPTH(QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_push     (q_push),
		.q_job      (q_job),
		.q_full     (q_full),
		.q_pop      (q_pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// Back end: one result beat per cycle into the output register, which
	// keeps the last beat while the consumer holds off pop.
	mtc_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head_valid  (head_valid),
		.head_job    (head_job),
		.q_pop       (q_pop),
		.empty       (empty),
		.pop         (pop),
		.out_char    (out_char),
		.bad_input   (bad_input),
		.last_of_run (last_of_run)
	);

endmodule

// File: tb/morse_text_codec_core_tb.sv
// Self-checking testbench for morse_text_codec_core: encode and decode traffic against a
// built-in predictor, with random gaps on push and stalls on pop.
// Depends on mtc_pkg (character, symbol and table constants) and the core RTL only.
module morse_text_codec_core_tb import mtc_pkg::*; ();

	localparam int TOKEN_LIMIT   = MTC_MAX_SYMBOLS;
	localparam int SETTLE_CYCLES = 8;      // a decode byte with no beat never enters the job queue
	localparam int DRAIN_CYCLES  = 20;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int PHASE_BYTES   = 25;
	localparam bit DIR_ENCODE    = 1'b0;
	localparam bit DIR_DECODE    = 1'b1;

	// One result beat as the core should present it.
	typedef struct packed {
		logic [7:0] ch;
		logic       bad;
		logic       last;
	} morse_beat_t;

	logic       clk = 1'b0;
	logic       arst_n;
	logic       push;
	logic       full;
	logic [7:0] in_char;
	logic       end_of_line;
	logic       empty;
	logic       pop;
	logic [7:0] out_char;
	logic       bad_input;
	logic       last_of_run;
	logic       cfg_we;
	logic       cfg_wdata;

	// Character set and Morse patterns, same order: letters, digits 1..9 then 0, space.
	string glyph_set = "abcdefghijklmnopqrstuvwxyz1234567890 ";
	string morse_of [TABLE_SIZE] = '{
		".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..",
		".---", "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.",
		"...", "-", "..-", "...-", ".--", "-..-", "-.--", "--..",
		".----", "..---", "...--", "....-", ".....", "-....", "--...",
		"---..", "----.", "-----", "//"
	};
	logic [7:0] symbol_bytes [3] = '{CHAR_DOT, CHAR_DASH, CHAR_SLASH};

	// Predictor state: direction and the decode token being collected.
	bit              decode_mode;
	logic [SYM_W-1:0] token_bits;
	int              token_len;
	bit              token_overrun;
	morse_beat_t     beats_owed [$];

	int fails;
	int bytes_sent;
	int cycle_count;
	bit send_gaps;
	bit pop_stalls;

	morse_text_codec_core #(
		.MAX_SYMBOLS(TOKEN_LIMIT)
	) uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.in_char    (in_char),
		.end_of_line(end_of_line),
		.empty      (empty),
		.pop        (pop),
		.out_char   (out_char),
		.bad_input  (bad_input),
		.last_of_run(last_of_run),
		.cfg_we     (cfg_we),
		.cfg_wdata  (cfg_wdata)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard stop in case the core hangs.
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("[morse_text_codec_core] ERROR");
			$finish;
		end
	end

	// ---------------------------------------------------------------- predictor

	function automatic logic [1:0] symbol_code(input logic [7:0] c);
		if (c == CHAR_DOT)
			return SYM_DOT;
		if (c == CHAR_DASH)
			return SYM_DASH;
		if (c == CHAR_SLASH)
			return SYM_SLASH;
		return SYM_NONE;
	endfunction

	function automatic void owe_beat(input logic [7:0] ch, input logic bad);
		beats_owed.push_back('{ch: ch, bad: bad, last: 1'b0});
	endfunction

	// Token ends: emit its character if it matches a table entry, then start over.
	// Overlong or empty tokens emit nothing.
	function automatic void close_token();
		logic [SYM_W-1:0] pat_bits;
		bit               hit;
		hit = 1'b0;
		if (!token_overrun && token_len > 0 && token_len <= TABLE_MAX_LEN) begin
			for (int j = 0; j < TABLE_SIZE; j++) begin
				pat_bits = '0;
				for (int k = 0; k < morse_of[j].len(); k++)
					pat_bits |= SYM_W'(symbol_code(morse_of[j][k])) << (2 * k);
				if (!hit && morse_of[j].len() == token_len && pat_bits == token_bits) begin
					hit = 1'b1;
					owe_beat(glyph_set[j], 1'b0);
				end
			end
		end
		token_bits    = '0;
		token_len     = 0;
		token_overrun = 1'b0;
	endfunction

	// Works out every beat one accepted input byte causes and queues them in order.
	function automatic void translate_byte(input logic [7:0] c, input logic eol);
		int          first;
		int          hit_idx;
		logic [1:0]  code;
		morse_beat_t tail;
		first = beats_owed.size();
		if (!decode_mode) begin
			// encode: end_of_line is ignored and the token is left alone
			hit_idx = -1;
			for (int j = TABLE_SIZE - 1; j >= 0; j--)
				if (glyph_set[j] == c)
					hit_idx = j;
			if (hit_idx >= 0) begin
				for (int k = 0; k < morse_of[hit_idx].len(); k++)
					owe_beat(morse_of[hit_idx][k], 1'b0);
				owe_beat(CHAR_SPACE, 1'b0);
			end else begin
				owe_beat(8'd0, 1'b1);
			end
		end else begin
			code = symbol_code(c);
			if (code != SYM_NONE) begin
				if (token_len >= TOKEN_LIMIT) begin
					token_overrun = 1'b1;
				end else begin
					if (token_len < TABLE_MAX_LEN)
						token_bits |= SYM_W'(code) << (2 * token_len);
					token_len++;
				end
			end else if (c == CHAR_SPACE) begin
				close_token();
			end else begin
				// rejected byte: flagged beat, token untouched
				owe_beat(8'd0, 1'b1);
			end
			// end of line closes whatever is left, after the byte itself
			if (eol)
				close_token();
		end
		if (beats_owed.size() > first) begin
			tail      = beats_owed.pop_back();
			tail.last = 1'b1;
			beats_owed.push_back(tail);
		end
	endfunction

	// ---------------------------------------------------------------- result side

	function automatic void check_field(input string field, input logic [7:0] want,
			input logic [7:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", field, want, got);
			fails++;
		end
	endfunction

	// Takes each popped beat against the oldest owed one; pop is re-rolled every cycle.
	always @(posedge clk) begin
		morse_beat_t want;
		if (arst_n) begin
			if (pop && !empty) begin
				if (beats_owed.size() == 0) begin
					$error("unexpected beat: out_char %0d bad_input %0d last_of_run %0d",
						out_char, bad_input, last_of_run);
					fails++;
				end else begin
					want = beats_owed.pop_front();
					check_field("out_char", want.ch, out_char);
					check_field("bad_input", 8'(want.bad), 8'(bad_input));
					check_field("last_of_run", 8'(want.last), 8'(last_of_run));
				end
			end
			pop <= !(pop_stalls && $urandom_range(99) < 20);
		end
	end

	// ---------------------------------------------------------------- input side

	// Offers one byte, holds it until the core takes it, then predicts its beats.
	// push is lowered only before a gap or by wait_drained, so back-to-back bytes keep it high.
	task automatic send_byte(input logic [7:0] c, input logic eol);
		if (send_gaps && $urandom_range(99) < 20) begin
			push <= 1'b0;
			repeat ($urandom_range(1, 4)) @(posedge clk);
		end
		push        <= 1'b1;
		in_char     <= c;
		end_of_line <= eol;
		do
			@(posedge clk);
		while (full);
		translate_byte(c, eol);
		bytes_sent++;
	endtask

	// Stops pushing and waits until every owed beat has been popped.
	task automatic wait_drained();
		push <= 1'b0;
		do
			@(posedge clk);
		while (beats_owed.size() != 0);
	endtask

	// Direction changes only with the core idle; a decode byte with no beat never enters the job queue.
	task automatic set_direction(input bit dir);
		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= dir;
		@(posedge clk);
		cfg_we      <= 1'b0;
		decode_mode = dir;
	endtask

	// ---------------------------------------------------------------- tests

	// Table edges, out-of-table bytes and the byte extremes; eol must not matter.
	task automatic test_encode_edges();
		set_direction(DIR_ENCODE);
		send_byte(CHAR_LC_A, 1'b0);
		send_byte(CHAR_LC_Z, 1'b1);
		send_byte(CHAR_ZERO, 1'b0);
		send_byte(CHAR_NINE, 1'b1);
		send_byte(CHAR_SPACE, 1'b0);
		send_byte("A", 1'b0);
		send_byte(8'h00, 1'b1);
		send_byte(8'hff, 1'b0);
	endtask

	task automatic test_decode_special_cases();
		set_direction(DIR_DECODE);
		// plain token ended by space
		send_byte(CHAR_DOT, 1'b0);
		send_byte(CHAR_DASH, 1'b0);
		send_byte(CHAR_SPACE, 1'b0);
		// rejected byte on the eol beat: flag first, then the token's character
		send_byte(CHAR_DOT, 1'b0);
		send_byte(8'hff, 1'b1);
		// symbol on the eol beat joins the token before it closes
		send_byte(CHAR_SLASH, 1'b0);
		send_byte(CHAR_SLASH, 1'b1);
		// space on the eol beat: one character only
		send_byte(CHAR_DASH, 1'b0);
		send_byte(CHAR_SPACE, 1'b1);
		// empty token
		send_byte(CHAR_SPACE, 1'b0);
		// six symbols: overlong token, nothing comes out
		repeat (5) send_byte(CHAR_DOT, 1'b0);
		send_byte(CHAR_DOT, 1'b1);
	endtask

	// Token survives a trip through encode mode.
	task automatic test_direction_keeps_token();
		set_direction(DIR_DECODE);
		send_byte(CHAR_DASH, 1'b0);
		send_byte(CHAR_DASH, 1'b0);
		set_direction(DIR_ENCODE);
		send_byte("e", 1'b1);
		set_direction(DIR_DECODE);
		send_byte(CHAR_SPACE, 1'b1);
	endtask

	// One decode word: mostly a real pattern, sometimes a random symbol run (often overlong)
	// or a stray byte.
	task automatic send_decode_word();
		int roll;
		int j;
		int n;
		bit eol_end;
		roll = $urandom_range(99);
		if (roll < 75) begin
			j       = $urandom_range(TABLE_SIZE - 1);
			n       = morse_of[j].len();
			eol_end = ($urandom_range(3) == 0);
			for (int k = 0; k < n; k++) begin
				if ($urandom_range(19) == 0)
					send_byte(8'($urandom_range(255)), 1'b0);
				send_byte(morse_of[j][k], eol_end && k == n - 1);
			end
			if (!eol_end)
				send_byte(CHAR_SPACE, $urandom_range(7) == 0);
		end else if (roll < 88) begin
			n = $urandom_range(1, 8);
			repeat (n) send_byte(symbol_bytes[$urandom_range(2)], 1'b0);
			send_byte(CHAR_SPACE, 1'($urandom_range(1)));
		end else begin
			send_byte(8'($urandom_range(255)), 1'($urandom_range(1)));
		end
	endtask

	task automatic test_random_traffic();
		int phase_start;
		for (int ph = 0; ph < 6; ph++) begin
			set_direction(ph[0] ? DIR_DECODE : DIR_ENCODE);
			// one phase runs flat out on both sides
			send_gaps   = (ph != 3);
			pop_stalls  = (ph != 3);
			phase_start = bytes_sent;
			while (bytes_sent < phase_start + PHASE_BYTES) begin
				if (ph == 2 && bytes_sent == phase_start + PHASE_BYTES / 2)
					wait_drained();
				if (decode_mode)
					send_decode_word();
				else if ($urandom_range(99) < 75)
					send_byte(glyph_set[$urandom_range(TABLE_SIZE - 1)], $urandom_range(7) == 0);
				else
					send_byte(8'($urandom_range(255)), $urandom_range(7) == 0);
			end
		end
		send_gaps  = 1'b1;
		pop_stalls = 1'b1;
	endtask

	// ---------------------------------------------------------------- sequence

	initial begin
		arst_n        = 1'b0;
		push          = 1'b0;
		in_char       = 8'd0;
		end_of_line   = 1'b0;
		pop           = 1'b0;
		cfg_we        = 1'b0;
		cfg_wdata     = 1'b0;
		decode_mode   = DIR_ENCODE;
		token_bits    = '0;
		token_len     = 0;
		token_overrun = 1'b0;
		fails         = 0;
		bytes_sent    = 0;
		cycle_count   = 0;
		send_gaps     = 1'b1;
		pop_stalls    = 1'b1;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_encode_edges();
		test_decode_special_cases();
		test_direction_keeps_token();
		test_random_traffic();

		// everything owed has arrived; watch a little longer for strays
		wait_drained();
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (fails == 0)
			$display("[morse_text_codec_core] OK");
		else
			$display("[morse_text_codec_core] ERROR");
		$finish;
	end

endmodule
